### rtl/spq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH      = 64;
    localparam int TAG_WIDTH  = 32;
    localparam int PRIO_WIDTH = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OCC_W      = 7;

    typedef logic [TAG_WIDTH-1:0]  t_tag;
    typedef logic [PRIO_WIDTH-1:0] t_prio;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic  enq;
        logic  deq;
        t_tag  tag;
        t_prio prio;
    } t_bcast;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// One storage cell of the sorted chain: holds a tag and a priority.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire         i_clk,
    input  wire t_bcast i_op,
    input  wire         i_occ,
    input  wire         i_left_flag,
    input  wire t_tag   i_left_tag,
    input  wire t_prio  i_left_prio,
    input  wire t_tag   i_right_tag,
    input  wire t_prio  i_right_prio,
    output logic        o_flag,
    output t_tag        o_tag,
    output t_prio       o_prio
);

    t_tag  r_tag;
    t_prio r_prio;
    t_tag  n_tag;
    t_prio n_prio;
    logic  n_we;

    // Flag cells that the new entry goes in front of (or that are free)
    assign o_flag = !i_occ || (i_op.prio < r_prio);

    // Pick the next contents: shift down, shift up, take the new entry or hold
    always_comb begin
        n_we   = 1'b0;
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_op.deq) begin
            n_we   = 1'b1;
            n_tag  = i_right_tag;
            n_prio = i_right_prio;
        end else if (i_op.enq && o_flag) begin
            n_we = 1'b1;
            if (i_left_flag) begin
                n_tag  = i_left_tag;
                n_prio = i_left_prio;
            end else begin
                n_tag  = i_op.tag;
                n_prio = i_op.prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_tag  <= n_tag;
            r_prio <= n_prio;
        end
    end

    assign o_tag  = r_tag;
    assign o_prio = r_prio;

endmodule

`default_nettype wire

### rtl/sorted_insert_priority_queue_unit.sv
// Top level of the sorted-insert priority queue: cell chain, count and result register.
//
// Usage:
//   Input channel (i_valid / o_stall) carries a command: enqueue i_tag with
//   priority i_prio, or dequeue the entry with the smallest priority. Equal
//   priorities leave in arrival order. Output channel (o_valid / i_stall)
//   returns one result per command: status, removed tag and priority (zero
//   unless a dequeue succeeded) and the occupancy after the command.
//   An enqueue on a full queue returns full status and changes nothing; a
//   dequeue on an empty queue returns empty status.
// Timing:
//   All cells compare against the new priority in parallel and shift by one
//   place in the same edge, so a command is accepted in every cycle unless
//   o_stall is raised; the result is registered and appears in the next cycle.
// Reset:
//   Synchronous active-low reset empties the queue and drops any pending
//   result. No clearing pass is needed; stored entries beyond the count
//   are never read.
// Stall:
//   While a result is held by i_stall, o_stall is raised and no further
//   command is accepted; the held result does not change.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_priority_queue_unit import spq_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire                    i_cmd,
    input  wire  [TAG_WIDTH-1:0]   i_tag,
    input  wire  [PRIO_WIDTH-1:0]  i_prio,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [1:0]             o_status,
    output logic [TAG_WIDTH-1:0]   o_out_tag,
    output logic [PRIO_WIDTH-1:0]  o_out_prio,
    output logic [OCC_W-1:0]       o_occupancy
);

    t_cnt    r_count;
    t_cnt    n_count;
    logic    r_valid;
    t_status r_status;
    t_status n_status;
    t_tag    r_out_tag;
    t_tag    n_out_tag;
    t_prio   r_out_prio;
    t_prio   n_out_prio;

    logic    w_accept;
    logic    w_full;
    logic    w_empty;
    t_bcast  w_op;

    logic    w_flag [DEPTH];
    t_tag    w_tag  [DEPTH];
    t_prio   w_prio [DEPTH];

    // Take a transaction unless a result is held by the receiver
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    // Broadcast the operation to the chain
    always_comb begin
        w_op.enq  = w_accept && (t_cmd'(i_cmd) == CMD_ENQ) && !w_full;
        w_op.deq  = w_accept && (t_cmd'(i_cmd) == CMD_DEQ) && !w_empty;
        w_op.tag  = i_tag;
        w_op.prio = i_prio;
    end

    // Build the chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic  w_occ;
            logic  w_lflag;
            t_tag  w_ltag;
            t_prio w_lprio;
            t_tag  w_rtag;
            t_prio w_rprio;

            assign w_occ = (r_count > CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign w_lflag = 1'b0;
                assign w_ltag  = '0;
                assign w_lprio = '0;
            end else begin : g_mid
                assign w_lflag = w_flag[gi-1];
                assign w_ltag  = w_tag[gi-1];
                assign w_lprio = w_prio[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_rtag  = '0;
                assign w_rprio = '0;
            end else begin : g_inner
                assign w_rtag  = w_tag[gi+1];
                assign w_rprio = w_prio[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_op         (w_op),
                .i_occ        (w_occ),
                .i_left_flag  (w_lflag),
                .i_left_tag   (w_ltag),
                .i_left_prio  (w_lprio),
                .i_right_tag  (w_rtag),
                .i_right_prio (w_rprio),
                .o_flag       (w_flag[gi]),
                .o_tag        (w_tag[gi]),
                .o_prio       (w_prio[gi])
            );
        end
    endgenerate

    // Work out the result and the new count
    always_comb begin
        n_count    = r_count;
        n_status   = ST_DONE;
        n_out_tag  = '0;
        n_out_prio = '0;
        unique case (t_cmd'(i_cmd))
            CMD_ENQ: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DEQ: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count    = r_count - CNT_W'(1);
                    n_out_tag  = w_tag[0];
                    n_out_prio = w_prio[0];
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Advance count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_out_tag  <= n_out_tag;
            r_out_prio <= n_out_prio;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_tag   = r_out_tag;
    assign o_out_prio  = r_out_prio;
    assign o_occupancy = OCC_W'(r_count);

endmodule

`default_nettype wire
